// ===== rtl/b64c_pkg.sv =====
// Shared types, constants and alphabet functions for the Base64 stream codec.
package b64c_pkg;

   localparam int unsigned JOBQ_DEPTH = 2;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // One unit of work for the back end: one or two result characters.
   typedef struct packed {
      logic       two;
      logic [7:0] c0;
      logic [7:0] c1;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } jobq_status_type;

   function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
      logic [7:0] r;
      begin
         if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
         end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v} - 8'd26;
         end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v} - 8'd52;
         end else if (v == 6'd62) begin
            r = 8'h2B;
         end else begin
            r = 8'h2F;
         end
         return r;
      end
   endfunction

   // Bit 6 set means the character is outside the alphabet.
   function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
      logic [7:0] r;
      begin
         if (c >= 8'h41 && c <= 8'h5A) begin
            r = c - 8'h41;
         end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h61 + 8'd26;
         end else if (c >= 8'h30 && c <= 8'h39) begin
            r = c - 8'h30 + 8'd52;
         end else if (c == 8'h2B) begin
            r = 8'd62;
         end else if (c == 8'h2F) begin
            r = 8'd63;
         end else begin
            r = 8'd64;
         end
         return r[6:0];
      end
   endfunction

endpackage

// ===== rtl/b64c_front.sv =====
// Front end: accepts words, updates the bit accumulator and forms result jobs.
module b64c_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_char,
   input  logic              in_last,
   input  logic              cfg_write,
   input  logic              cfg_mode,
   output logic              job_push,
   output b64c_pkg::job_type job
);

   logic       mode_ff, mode_in;
   logic [5:0] bits_ff, bits_in;
   logic [2:0] count_ff, count_in;

   always_comb begin
      logic [3:0]  cnt1, cnt2;
      logic [13:0] acc0, acc1, acc2, pad;
      logic [5:0]  s0, s1;
      logic [1:0]  n;
      logic [6:0]  sx;
      logic [3:0]  dcnt;
      logic [11:0] dacc;
      logic [7:0]  dbyte;

      mode_in  = mode_ff;
      bits_in  = bits_ff;
      count_in = count_ff;
      job      = '0;
      job_push = 1'b0;

      // Encode path: at least eight bits are present, so one group always leaves.
      acc0 = {bits_ff, in_char};
      cnt1 = {1'b0, count_ff} + 4'd2;
      s0   = acc0[5:0];
      s0   = 6'(acc0 >> cnt1);
      acc1 = acc0 & ((14'd1 << cnt1) - 14'd1);
      n    = 2'd1;
      s1   = '0;
      if (cnt1 >= 4'd6) begin
         cnt2 = cnt1 - 4'd6;
         s1   = 6'(acc1 >> cnt2);
         acc2 = acc1 & ((14'd1 << cnt2) - 14'd1);
         n    = 2'd2;
      end else begin
         cnt2 = cnt1;
         acc2 = acc1;
      end
      pad = acc2 << (4'd6 - cnt2);
      if (in_last && cnt2 != 4'd0 && cnt2 < 4'd6 && n == 2'd1) begin
         s1 = pad[5:0];
         n  = 2'd2;
      end

      // Decode path.
      sx    = b64c_pkg::char_to_sextet(in_char);
      dacc  = {bits_ff, sx[5:0]};
      dcnt  = {1'b0, count_ff} + 4'd6;
      dbyte = '0;

      if (accept) begin
         if (mode_ff == b64c_pkg::MODE_ENCODE) begin
            job_push = 1'b1;
            job.two  = (n == 2'd2);
            job.c0   = b64c_pkg::sextet_to_char(s0);
            job.c1   = b64c_pkg::sextet_to_char(s1);
            bits_in  = acc2[5:0];
            count_in = cnt2[2:0];
         end else if (!sx[6]) begin
            if (dcnt >= 4'd8) begin
               dcnt     = dcnt - 4'd8;
               dbyte    = 8'(dacc >> dcnt);
               dacc     = dacc & ((12'd1 << dcnt) - 12'd1);
               job_push = 1'b1;
               job.c0   = dbyte;
            end
            bits_in  = dacc[5:0];
            count_in = dcnt[2:0];
         end
         if (in_last) begin
            bits_in  = '0;
            count_in = '0;
         end
      end

      if (cfg_write) begin
         mode_in  = cfg_mode;
         bits_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= b64c_pkg::MODE_ENCODE;
         bits_ff  <= '0;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         bits_ff  <= bits_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/b64c_jobq.sv =====
// Short job queue between the front end and the back end.
module b64c_jobq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  b64c_pkg::job_type         push_job,
   input  logic                      pop,
   output b64c_pkg::job_type         head_job,
   output b64c_pkg::jobq_status_type status
);

   localparam int unsigned DEPTH = b64c_pkg::JOBQ_DEPTH;
   localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW    = $clog2(DEPTH + 1);

   b64c_pkg::job_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CW'(DEPTH));
   assign head_job     = entry_ff[rd_ptr_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/b64c_back.sv =====
// Back end: splits jobs into single result words held in the output register.
module b64c_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  b64c_pkg::job_type head_job,
   output logic              head_pop,
   input  logic              out_pop,
   output logic              out_valid,
   output logic [7:0]        out_char,
   output logic              out_last
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       idx_ff, idx_in;
   logic       load;

   assign load     = head_valid && (!valid_ff || out_pop);
   assign head_pop = load && (idx_ff || !head_job.two);

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (out_pop && valid_ff) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         char_in  = idx_ff ? head_job.c1 : head_job.c0;
         last_in  = idx_ff || !head_job.two;
         idx_in   = !(idx_ff || !head_job.two);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule

// ===== rtl/base64_stream_codec.sv =====
// Top level of the streaming Base64 encoder and decoder.
//
// Input side is a queue: present req_in_char and req_in_last with req_push; a
// word is taken at a clock edge where req_push is high and req_full is low.
// Results come out of a queue: while rsp_empty is low, rsp_out_char and
// rsp_out_run_last show the oldest result, taken on an edge with rsp_pop high.
// csr_mode (0 encode, 1 decode) is written when csr_valid is high; csr_ready is
// always high. A write clears the partial bit group.
//
// The first result of a taken word passes through the job queue and then the
// output register; the second character of an encoded byte follows the first.
// Throughput: while the receiver pops, the output register delivers one result
// per cycle; encoding gives one or two characters per byte, and decoding takes
// one character per cycle while req_full is low. The two-entry job queue between
// the front end and the output stage sets how far input runs ahead of output.
// When the receiver stalls, the output word holds, the job queue fills and
// req_full rises. Reset selects encode mode and empties all queues.
module base64_stream_codec (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_char,
   input  logic       req_in_last,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_out_run_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_mode
);

   b64c_pkg::job_type         front_job, head_job;
   b64c_pkg::jobq_status_type q_status;
   logic                      accept, job_push, head_pop, out_valid;

   assign csr_ready = 1'b1;
   assign req_full  = q_status.full;
   assign accept    = req_push && !q_status.full;
   assign rsp_empty = !out_valid;

   b64c_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_char   (req_in_char),
      .in_last   (req_in_last),
      .cfg_write (csr_valid && csr_ready),
      .cfg_mode  (csr_mode),
      .job_push  (job_push),
      .job       (front_job)
   );

   b64c_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (front_job),
      .pop      (head_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   b64c_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_status.empty),
      .head_job   (head_job),
      .head_pop   (head_pop),
      .out_pop    (rsp_pop),
      .out_valid  (out_valid),
      .out_char   (rsp_out_char),
      .out_last   (rsp_out_run_last)
   );

   // The front end never produces a job while the queue is full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(job_push && q_status.full))
      else $error("job pushed into a full queue");

   // A job is only retired while the output stage loads a word.
   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> (!q_status.empty && (rsp_empty || rsp_pop)))
      else $error("job retired without loading the output stage");

   // An accepted word with req_in_last set ends the message: no partial bits remain in the front end.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_in_last) |=> (u_front.count_ff == 3'd0))
      else $error("pending bits survived the end of a message");

endmodule

// ===== bench/tb_base64_stream_codec.sv =====
// Self-checking testbench for the streaming Base64 encoder and decoder.
module tb_base64_stream_codec;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 300;
   localparam int PHASES       = 14;
   localparam int PHASE_WORDS  = 125;
   localparam int REPORT_LIMIT = 10;
   localparam logic [7:0] PAD_CHAR = "=";

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
   } rsp_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_in_char = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_out_run_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_mode = 1'b0;

   base64_stream_codec dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_in_char      (req_in_char),
      .req_in_last      (req_in_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_char     (rsp_out_char),
      .rsp_out_run_last (rsp_out_run_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_mode         (csr_mode)
   );

   string b64_alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   // Bit 6 set marks a character outside the alphabet.
   logic [6:0] glyph_code [256];

   req_word_type req_backlog [$];
   rsp_word_type rsp_expected [$];

   // Predicted codec state.
   logic       pred_mode;
   logic [5:0] pred_bits;
   logic [2:0] pred_count;

   int  fail_count = 0;
   bit  no_idle = 1'b0;
   int  stall_requests = 0;
   int  stall_served = 0;
   int  hold_left = 0;
   req_word_type taken_word;
   rsp_word_type due_word;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit take_break();
      return !no_idle && ($urandom_range(99) < 33);
   endfunction

   task automatic codec_predict(input logic [7:0] c, input logic last);
      int         cnt;
      int         n;
      logic [13:0] acc;
      logic [13:0] tmp;
      logic [6:0] code;
      logic [7:0] outs [2];
      rsp_word_type w;
      n = 0;
      if (pred_mode == b64c_pkg::MODE_ENCODE) begin
         cnt = pred_count + 8;
         acc = {pred_bits, c};
         while (cnt >= 6 && n < 2) begin
            cnt -= 6;
            tmp = acc >> cnt;
            outs[n] = b64_alphabet[tmp[5:0]];
            n++;
            acc = acc & ((14'd1 << cnt) - 14'd1);
         end
         if (last && cnt > 0 && n < 2) begin
            // Zero-fill the short final group out to six bits.
            tmp = acc << (6 - cnt);
            outs[n] = b64_alphabet[tmp[5:0]];
            n++;
         end
         pred_bits  = last ? 6'd0 : acc[5:0];
         pred_count = last ? 3'd0 : cnt[2:0];
      end else begin
         code = glyph_code[c];
         if (!code[6]) begin
            cnt = pred_count + 6;
            acc = {2'b00, pred_bits, code[5:0]};
            if (cnt >= 8) begin
               cnt -= 8;
               tmp = acc >> cnt;
               outs[0] = tmp[7:0];
               n = 1;
               acc = acc & ((14'd1 << cnt) - 14'd1);
            end
            pred_bits  = acc[5:0];
            pred_count = cnt[2:0];
         end
         if (last) begin
            pred_bits  = 6'd0;
            pred_count = 3'd0;
         end
      end
      for (int i = 0; i < n; i++) begin
         w.data     = outs[i];
         w.run_last = (i == n - 1);
         rsp_expected.push_back(w);
      end
   endtask

   task automatic push_word(input logic [7:0] c, input logic last);
      req_word_type w;
      w.data = c;
      w.last = last;
      req_backlog.push_back(w);
   endtask

   task automatic wait_idle();
      while (req_backlog.size() != 0 || rsp_expected.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_mode  <= m;
      do @(posedge clock); while (csr_ready !== 1'b1);
      pred_mode  = m;
      pred_bits  = 6'd0;
      pred_count = 3'd0;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sender: present the oldest pending word at the falling edge, unless taking a random break.
   always @(negedge clock) begin
      if (reset || req_backlog.size() == 0 || take_break()) begin
         req_push <= 1'b0;
      end else begin
         req_push    <= 1'b1;
         req_in_char <= req_backlog[0].data;
         req_in_last <= req_backlog[0].last;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         taken_word = req_backlog.pop_front();
         codec_predict(taken_word.data, taken_word.last);
      end
   end

   // Receiver: a requested stall holds pop low until hold_left runs out.
   always @(negedge clock) begin
      if (stall_served != stall_requests) begin
         stall_served = stall_requests;
         hold_left    = LONG_HOLD;
      end
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !take_break();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (rsp_expected.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
               $display("unexpected result word: char %h run_last %b",
                        rsp_out_char, rsp_out_run_last);
            end
         end else begin
            due_word = rsp_expected.pop_front();
            if (due_word.data !== rsp_out_char ||
                due_word.run_last !== rsp_out_run_last) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("result mismatch: out_char exp %h got %h, run_last exp %b got %b",
                           due_word.data, rsp_out_char, due_word.run_last,
                           rsp_out_run_last);
               end
            end
         end
      end
   end

   initial begin
      int         counted;
      int         len;
      int         pick;
      logic [7:0] ch;
      logic       last;
      logic       m;

      for (int k = 0; k < 256; k++) glyph_code[k] = 7'h40;
      for (int k = 0; k < 64; k++) glyph_code[b64_alphabet[k]] = k[6:0];
      pred_mode  = b64c_pkg::MODE_ENCODE;
      pred_bits  = 6'd0;
      pred_count = 3'd0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Encoding: byte extremes, one- and two-byte tails, '+' and '/'.
      write_mode(b64c_pkg::MODE_ENCODE);
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'h00, 1'b1);
      push_word(8'hFF, 1'b1);
      push_word(8'hFB, 1'b0);
      push_word(8'hEF, 1'b1);
      push_word(8'hFF, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word(8'hFF, 1'b1);
      // A write in the middle of a message must drop the partial group.
      push_word(8'h5A, 1'b0);
      write_mode(b64c_pkg::MODE_ENCODE);
      push_word(8'h5A, 1'b1);

      // Decoding: alphabet edges, ignored characters, drop on message end.
      write_mode(b64c_pkg::MODE_DECODE);
      push_word("A", 1'b0);
      push_word("Z", 1'b0);
      push_word("a", 1'b0);
      push_word("z", 1'b0);
      push_word("0", 1'b0);
      push_word("9", 1'b0);
      push_word("+", 1'b0);
      push_word("/", 1'b1);
      push_word(PAD_CHAR, 1'b0);
      push_word(8'h00, 1'b0);
      push_word(8'hFF, 1'b0);
      push_word("Q", 1'b0);
      push_word(PAD_CHAR, 1'b1);
      push_word("T", 1'b0);
      push_word("W", 1'b0);
      write_mode(b64c_pkg::MODE_DECODE);
      push_word("T", 1'b0);
      push_word("W", 1'b0);
      push_word("F", 1'b0);
      push_word("u", 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         m = (phase < 4) ? phase[0] : 1'($urandom_range(1));
         write_mode(m);
         no_idle = (phase == 5);
         if (phase == 3 || phase == 10) stall_requests++;
         counted = 0;
         while (counted < PHASE_WORDS) begin
            // A message is occasionally left open to run into the next one.
            if (m == b64c_pkg::MODE_ENCODE) begin
               len = $urandom_range(1, 9);
               for (int i = 0; i < len; i++) begin
                  last = (i == len - 1) && ($urandom_range(9) != 0);
                  push_word(8'($urandom_range(255)), last);
                  counted++;
               end
            end else begin
               len = $urandom_range(1, 14);
               for (int i = 0; i < len; i++) begin
                  pick = $urandom_range(99);
                  if (pick < 8) begin
                     ch = PAD_CHAR;
                  end else if (pick < 16) begin
                     ch = 8'($urandom_range(255));
                  end else begin
                     ch = b64_alphabet[$urandom_range(63)];
                  end
                  last = (i == len - 1) && ($urandom_range(9) != 0);
                  push_word(ch, last);
                  if (!glyph_code[ch][6] || last) counted++;
               end
            end
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("tb_base64_stream_codec OK");
      end else begin
         $display("tb_base64_stream_codec NOT OK");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_base64_stream_codec NOT OK");
      $finish;
   end

endmodule
